// ===== hw/rtl/slt_pkg.sv =====
package slt_pkg;

  localparam int DEPTH       = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CMD_W       = 3;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_REMOVE_MIN = 3'd1,
    CMD_REMOVE_MAX = 3'd2,
    CMD_READ       = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_e;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic   insert;     // insert transaction, table not full
    logic   shift_down; // remove-smallest transaction, table not empty
    value_t value;      // value being inserted
  } cell_ctl_t;

endpackage

// ===== hw/rtl/slt_if.sv =====
interface slt_req_if import slt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  value_t             value;
  logic [IDX_W-1:0]   index;

  modport source (output valid, cmd, value, index, input ready);
  modport sink   (input valid, cmd, value, index, output ready);
endinterface

interface slt_rsp_if import slt_pkg::*; ();
  logic               valid;
  logic               ready;
  value_t             result_value;
  logic               ok;
  logic [CNT_W-1:0]   count;

  modport source (output valid, result_value, ok, count, input ready);
  modport sink   (input valid, result_value, ok, count, output ready);
endinterface

// ===== hw/rtl/slt_cell.sv =====
module slt_cell import slt_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      valid_i,        // this cell holds a live entry
  input  value_t    left_val_i,
  input  logic      left_beyond_i,  // left neighbor sits at or past the insert point
  input  value_t    right_val_i,
  output value_t    val_o,
  output logic      beyond_o
);

  value_t val_q, val_d;

  // Insert lands after equal values: strictly greater or empty moves right.
  assign beyond_o = !valid_i || (val_q > ctl_i.value);
  assign val_o    = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.insert && beyond_o) begin
      val_d = left_beyond_i ? left_val_i : ctl_i.value;
    end else if (ctl_i.shift_down) begin
      val_d = right_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== hw/rtl/sorted_list_table.sv =====
// Sorted table of up to DEPTH signed values kept in ascending order, usable
// as a double-ended priority queue. Each request transaction carries a cmd:
// insert (placed after equal values), remove smallest, remove largest, read
// at index, or clear. Every request gives exactly one response transaction
// with the removed or read value (zero when not meaningful), an ok flag and
// the entry count after the operation. Insert into a full table, removal
// from an empty one, a read at or beyond the count and unknown commands
// report ok = 0 and leave the table unchanged. Storage is a row of DEPTH
// cells; each cell compares its entry with the broadcast insert value and
// takes its own, its left or its right neighbor's value in the same cycle,
// so each operation is done as the cells load. Throughput is one request per
// cycle while responses are drained. The response sits in an output register
// and appears in the cycle after acceptance; a new request is taken while
// that register is empty or being drained. There is no clearing pass after
// reset: the count register alone marks which cells are live.
module sorted_list_table import slt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  slt_req_if.sink   req_i,
  slt_rsp_if.source rsp_o
);

  // Handshake
  logic rsp_valid_q;
  logic accept;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Entry count
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] count_m1;
  logic             is_full, is_empty;

  assign is_full  = (count_q == CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign count_m1 = count_q - 1'b1;

  // Cell row
  cell_ctl_t ctl;
  value_t    cell_val    [DEPTH];
  logic      cell_beyond [DEPTH];

  assign ctl.insert     = accept && (req_i.cmd == CMD_INSERT) && !is_full;
  assign ctl.shift_down = accept && (req_i.cmd == CMD_REMOVE_MIN) && !is_empty;
  assign ctl.value      = req_i.value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t left_val, right_val;
    logic   left_beyond;

    if (i == 0) begin : g_first
      assign left_val    = '0;
      assign left_beyond = 1'b0;
    end else begin : g_mid
      assign left_val    = cell_val[i-1];
      assign left_beyond = cell_beyond[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = '0;   // vacated slot, no longer live
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    slt_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .valid_i       (CNT_W'(i) < count_q),
      .left_val_i    (left_val),
      .left_beyond_i (left_beyond),
      .right_val_i   (right_val),
      .val_o         (cell_val[i]),
      .beyond_o      (cell_beyond[i])
    );
  end

  // Read port: one selector serves read-at-index and remove-largest
  logic [IDX_W-1:0] rd_addr;
  value_t           rd_val;

  assign rd_addr = (req_i.cmd == CMD_READ) ? req_i.index : count_m1[IDX_W-1:0];
  assign rd_val  = cell_val[rd_addr];

  // Result
  value_t res_d, res_q;
  logic   ok_d, ok_q;
  logic [CNT_W-1:0] rsp_count_q;

  always_comb begin
    res_d   = '0;
    ok_d    = 1'b0;
    count_d = count_q;
    case (req_i.cmd)
      CMD_INSERT: begin
        if (!is_full) begin
          ok_d    = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      CMD_REMOVE_MIN: begin
        if (!is_empty) begin
          ok_d    = 1'b1;
          res_d   = cell_val[0];
          count_d = count_m1;
        end
      end
      CMD_REMOVE_MAX: begin
        if (!is_empty) begin
          ok_d    = 1'b1;
          res_d   = rd_val;
          count_d = count_m1;
        end
      end
      CMD_READ: begin
        if ({1'b0, req_i.index} < count_q) begin
          ok_d  = 1'b1;
          res_d = rd_val;
        end
      end
      CMD_CLEAR: begin
        ok_d    = 1'b1;
        count_d = '0;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Response payload, loaded with each request transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q       <= res_d;
      ok_q        <= ok_d;
      rsp_count_q <= count_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.result_value = res_q;
  assign rsp_o.ok           = ok_q;
  assign rsp_o.count        = rsp_count_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond table depth");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (req_i.cmd == CMD_INSERT) && !is_full
      |=> rsp_o.ok && (rsp_o.count == $past(count_q) + 1'b1))
    else $error("insert did not grow the count by one");

  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_empty &&
      ((req_i.cmd == CMD_REMOVE_MIN) || (req_i.cmd == CMD_REMOVE_MAX))
      |=> !rsp_o.ok && (rsp_o.count == '0))
    else $error("remove from empty table reported success");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && !ok_q |-> (res_q == '0))
    else $error("failed response carries a nonzero value");

endmodule
